FILE: rtl/dssa_pkg.sv
package dssa_pkg;

    // Operand A of the shared multiplier: a 33 bit displacement, sign extended.
    localparam int unsigned MUL_AW = 34;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_RETARGET = 2'd1,
        OP_TICK     = 2'd2,
        OP_RECLAMP  = 2'd3
    } t_op;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_STIFFNESS = 3'd0,
        REG_DAMPING   = 3'd1,
        REG_POS_TOL   = 3'd2,
        REG_VEL_TOL   = 3'd3,
        REG_MIN_X     = 3'd4,
        REG_MAX_X     = 3'd5,
        REG_MIN_Y     = 3'd6,
        REG_MAX_Y     = 3'd7
    } t_reg;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MS_STIFF_DT = 3'd0,
        MS_DAMP_DT  = 3'd1,
        MS_DX_K     = 3'd2,
        MS_DY_K     = 3'd3,
        MS_VX_C     = 3'd4,
        MS_VY_C     = 3'd5,
        MS_VX_DT    = 3'd6,
        MS_VY_DT    = 3'd7
    } t_msel;

    typedef struct packed {
        logic        [15:0] stiffness;
        logic        [15:0] damping;
        logic        [15:0] position_tolerance;
        logic        [15:0] velocity_tolerance;
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Minimum bound wins when the extents are inverted.
    function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] t;
        t = (v < hi) ? v : hi;
        return (t > lo) ? t : lo;
    endfunction

endpackage

FILE: rtl/damped_spring_scroll_animator_top.sv
// Start, retarget, reclamp and idle ticks give their beat from state EXEC after acceptance.
// An advancing tick runs DISP and M0-M7 per substep, plus CK and CC whenever substep length
// changes (tick start, short final substep), then DISP and FIN; at most MAX_STEPS substeps.
// The shared multiplier is used six times per substep, sequenced over nine states.
// One item is processed at a time; a finished beat may wait while the next item is taken.
// Reset (synchronous, active low) clears position, velocity, destination and the running flag,
// and loads the register defaults.
module damped_spring_scroll_animator_top #(
    parameter int unsigned STEP_TIME = 64,
    parameter int unsigned MAX_STEPS = 400,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic   [4:0] paddr,
    input  logic  [31:0] pwdata,
    output logic  [31:0] prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // from_x[31:0], from_y[63:32], to_x[95:64], to_y[127:96], elapsed_time[143:128]
    input  logic [143:0] s_axis_tdata,
    // operation[1:0]
    input  logic   [1:0] s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accepted[0], running[1], finished[2], position_x[34:3], position_y[66:35], zero[71:67]
    output logic  [71:0] m_axis_tdata
);
    import dssa_pkg::*;

    t_cfg               w_cfg;
    logic               w_acc, w_run, w_fin;
    logic signed [31:0] w_px, w_py;

    dssa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dssa_core #(
        .STEP_TIME (STEP_TIME),
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (t_op'(s_axis_tuser)),
        .i_from_x   (s_axis_tdata[31:0]),
        .i_from_y   (s_axis_tdata[63:32]),
        .i_to_x     (s_axis_tdata[95:64]),
        .i_to_y     (s_axis_tdata[127:96]),
        .i_elapsed  (s_axis_tdata[143:128]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_accepted (w_acc),
        .o_running  (w_run),
        .o_finished (w_fin),
        .o_pos_x    (w_px),
        .o_pos_y    (w_py)
    );

    assign m_axis_tdata = {5'b0, w_py, w_px, w_fin, w_run, w_acc};

endmodule

FILE: rtl/dssa_mul.sv
module dssa_mul #(
    parameter int unsigned DT_W  = 7,
    parameter int unsigned KDT_W = 23
) (
    input  dssa_pkg::t_msel                    i_sel,
    input  logic                        [15:0] i_stiff,
    input  logic                        [15:0] i_damp,
    input  logic signed                 [32:0] i_dx,
    input  logic signed                 [32:0] i_dy,
    input  logic signed                 [31:0] i_vx,
    input  logic signed                 [31:0] i_vy,
    input  logic                   [KDT_W-1:0] i_kdt,
    input  logic                   [KDT_W-1:0] i_cdt,
    input  logic                    [DT_W-1:0] i_dt,
    output logic signed [dssa_pkg::MUL_AW+KDT_W:0] o_prod
);
    import dssa_pkg::*;

    localparam int unsigned BW = KDT_W + 1;
    localparam int unsigned PW = MUL_AW + BW;

    logic signed [MUL_AW-1:0] w_a;
    logic signed [BW-1:0]     w_b;

    always_comb begin
        case (i_sel)
            MS_STIFF_DT: begin
                w_a = $signed(MUL_AW'(i_stiff));
                w_b = $signed(BW'(i_dt));
            end
            MS_DAMP_DT: begin
                w_a = $signed(MUL_AW'(i_damp));
                w_b = $signed(BW'(i_dt));
            end
            MS_DX_K: begin
                w_a = MUL_AW'(i_dx);
                w_b = $signed(BW'(i_kdt));
            end
            MS_DY_K: begin
                w_a = MUL_AW'(i_dy);
                w_b = $signed(BW'(i_kdt));
            end
            MS_VX_C: begin
                w_a = MUL_AW'(i_vx);
                w_b = $signed(BW'(i_cdt));
            end
            MS_VY_C: begin
                w_a = MUL_AW'(i_vy);
                w_b = $signed(BW'(i_cdt));
            end
            MS_VX_DT: begin
                w_a = MUL_AW'(i_vx);
                w_b = $signed(BW'(i_dt));
            end
            MS_VY_DT: begin
                w_a = MUL_AW'(i_vy);
                w_b = $signed(BW'(i_dt));
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    logic signed [PW-1:0] w_pa;
    logic signed [PW-1:0] w_pb;

    assign w_pa   = PW'(w_a);
    assign w_pb   = PW'(w_b);
    assign o_prod = w_pa * w_pb;

endmodule

FILE: rtl/dssa_cfg.sv
module dssa_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic           [4:0] paddr,
    input  logic          [31:0] pwdata,
    output logic          [31:0] prdata,
    output logic                 pready,
    output dssa_pkg::t_cfg       o_cfg
);
    import dssa_pkg::*;

    localparam logic [15:0] RST_STIFFNESS = 16'd8120;
    localparam logic [15:0] RST_DAMPING   = 16'd2884;
    localparam logic [15:0] RST_POS_TOL   = 16'd256;
    localparam logic [15:0] RST_VEL_TOL   = 16'd1311;
    localparam logic [31:0] RST_MIN       = 32'h0000_0000;
    localparam logic [31:0] RST_MAX       = 32'h7fff_ffff;

    t_cfg r_cfg;
    t_reg w_idx;
    logic w_wr;

    assign w_idx  = t_reg'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stiffness          <= RST_STIFFNESS;
            r_cfg.damping            <= RST_DAMPING;
            r_cfg.position_tolerance <= RST_POS_TOL;
            r_cfg.velocity_tolerance <= RST_VEL_TOL;
            r_cfg.min_x              <= RST_MIN;
            r_cfg.max_x              <= RST_MAX;
            r_cfg.min_y              <= RST_MIN;
            r_cfg.max_y              <= RST_MAX;
        end else if (w_wr) begin
            case (w_idx)
                REG_STIFFNESS: r_cfg.stiffness          <= pwdata[15:0];
                REG_DAMPING:   r_cfg.damping            <= pwdata[15:0];
                REG_POS_TOL:   r_cfg.position_tolerance <= pwdata[15:0];
                REG_VEL_TOL:   r_cfg.velocity_tolerance <= pwdata[15:0];
                REG_MIN_X:     r_cfg.min_x              <= pwdata;
                REG_MAX_X:     r_cfg.max_x              <= pwdata;
                REG_MIN_Y:     r_cfg.min_y              <= pwdata;
                REG_MAX_Y:     r_cfg.max_y              <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_STIFFNESS: prdata = 32'(r_cfg.stiffness);
            REG_DAMPING:   prdata = 32'(r_cfg.damping);
            REG_POS_TOL:   prdata = 32'(r_cfg.position_tolerance);
            REG_VEL_TOL:   prdata = 32'(r_cfg.velocity_tolerance);
            REG_MIN_X:     prdata = r_cfg.min_x;
            REG_MAX_X:     prdata = r_cfg.max_x;
            REG_MIN_Y:     prdata = r_cfg.min_y;
            REG_MAX_Y:     prdata = r_cfg.max_y;
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: rtl/dssa_core.sv
module dssa_core #(
    parameter int unsigned STEP_TIME = 64,
    parameter int unsigned MAX_STEPS = 400,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dssa_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dssa_pkg::t_op        i_op,
    input  logic signed   [31:0] i_from_x,
    input  logic signed   [31:0] i_from_y,
    input  logic signed   [31:0] i_to_x,
    input  logic signed   [31:0] i_to_y,
    input  logic          [15:0] i_elapsed,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_accepted,
    output logic                 o_running,
    output logic                 o_finished,
    output logic signed   [31:0] o_pos_x,
    output logic signed   [31:0] o_pos_y
);
    import dssa_pkg::*;

    localparam int unsigned DT_W  = $clog2(STEP_TIME + 1);
    localparam int unsigned KDT_W = 16 + DT_W;
    localparam int unsigned PW    = MUL_AW + KDT_W + 1;
    localparam int unsigned SC_W  = $clog2(MAX_STEPS + 1);
    localparam int unsigned SH_K  = 12 + FRAC_BITS;
    localparam int unsigned SH_C  = 20;
    localparam int unsigned SH_P  = 20 - FRAC_BITS;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00_0000_0000_0001,
        S_EXEC = 14'b00_0000_0000_0010,
        S_DISP = 14'b00_0000_0000_0100,
        S_CK   = 14'b00_0000_0000_1000,
        S_CC   = 14'b00_0000_0001_0000,
        S_M0   = 14'b00_0000_0010_0000,
        S_M1   = 14'b00_0000_0100_0000,
        S_M2   = 14'b00_0000_1000_0000,
        S_M3   = 14'b00_0001_0000_0000,
        S_M4   = 14'b00_0010_0000_0000,
        S_M5   = 14'b00_0100_0000_0000,
        S_M6   = 14'b00_1000_0000_0000,
        S_M7   = 14'b01_0000_0000_0000,
        S_FIN  = 14'b10_0000_0000_0000
    } t_state;

    // Round to nearest, ties away from zero, then arithmetic shift.
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] x,
                                                 input int unsigned sh);
        logic signed [PW-1:0] bias;
        bias = $signed(PW'(1) << (sh - 1)) - $signed(PW'(x[PW-1]));
        return (x + bias) >>> sh;
    endfunction

    t_state n_state, r_state;

    // animation state
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_destx, r_desty;
    logic               r_active;

    // captured item
    t_op                r_op;
    logic signed [31:0] r_fx, r_fy, r_tx, r_ty;
    logic        [15:0] r_rem;

    // substep datapath
    logic signed [32:0]      r_dx, r_dy;
    logic                    r_bgx, r_bgy;
    logic [DT_W-1:0]         r_dt, r_coef_dt;
    logic                    r_coef_ok;
    logic [KDT_W-1:0]        r_kdt, r_cdt;
    logic signed [PW-1:0]    r_prod, r_accx, r_accy;
    logic [SC_W-1:0]         r_steps;

    // result register
    logic               r_ovalid, r_oacc, r_orun, r_ofin;
    logic signed [31:0] r_opx, r_opy;

    t_msel                w_sel;
    logic signed [PW-1:0] w_prod, w_rk, w_rc, w_rp;
    logic [DT_W-1:0]      w_dt;
    logic                 w_out_free, w_tick_run, w_loop_done, w_coef_stale;
    logic                 w_start_same, w_flip, w_near, w_snap, w_out_load;
    logic signed [31:0]   e_clx, e_cly, e_rcx, e_rcy;
    logic                 e_acc, e_run;
    logic [32:0]          w_adx, w_ady;
    logic [31:0]          w_avx, w_avy;

    dssa_mul #(
        .DT_W  (DT_W),
        .KDT_W (KDT_W)
    ) u_mul (
        .i_sel   (w_sel),
        .i_stiff (i_cfg.stiffness),
        .i_damp  (i_cfg.damping),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_vx    (r_vx),
        .i_vy    (r_vy),
        .i_kdt   (r_kdt),
        .i_cdt   (r_cdt),
        .i_dt    (r_dt),
        .o_prod  (w_prod)
    );

    assign w_rk = rnd(r_prod, SH_K);
    assign w_rc = rnd(r_prod, SH_C);
    assign w_rp = rnd(r_prod, SH_P);

    assign w_dt = (r_rem < 16'(STEP_TIME)) ? DT_W'(r_rem) : DT_W'(STEP_TIME);

    assign w_out_free   = !r_ovalid || i_ready;
    assign w_tick_run   = (r_op == OP_TICK) && r_active && (r_rem != '0);
    assign w_loop_done  = (r_rem == '0) || (r_steps == SC_W'(MAX_STEPS));
    assign w_coef_stale = !r_coef_ok || (r_coef_dt != w_dt);

    assign e_clx = clamp32(r_tx, i_cfg.min_x, i_cfg.max_x);
    assign e_cly = clamp32(r_ty, i_cfg.min_y, i_cfg.max_y);
    assign e_rcx = clamp32(r_destx, i_cfg.min_x, i_cfg.max_x);
    assign e_rcy = clamp32(r_desty, i_cfg.min_y, i_cfg.max_y);

    // start onto its own destination while idle loads position and destination but does not start running
    assign w_start_same = !r_active && (r_fx == e_clx) && (r_fy == e_cly);

    always_comb begin
        case (r_op)
            OP_START: begin
                e_acc = !w_start_same;
                e_run = r_active || !w_start_same;
            end
            OP_RETARGET: begin
                e_acc = r_active && !((e_clx == r_px) && (e_cly == r_py));
                e_run = r_active;
            end
            default: begin
                e_acc = 1'b1;
                e_run = r_active;
            end
        endcase
    end

    assign w_adx  = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_ady  = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign w_avx  = r_vx[31] ? 32'(-r_vx) : 32'(r_vx);
    assign w_avy  = r_vy[31] ? 32'(-r_vy) : 32'(r_vy);
    assign w_flip = (r_bgx != (r_dx > 33'sd0)) || (r_bgy != (r_dy > 33'sd0));
    assign w_near = (w_adx <= 33'(i_cfg.position_tolerance))
                 && (w_ady <= 33'(i_cfg.position_tolerance))
                 && (w_avx <= 32'(i_cfg.velocity_tolerance))
                 && (w_avy <= 32'(i_cfg.velocity_tolerance));
    assign w_snap = w_flip || w_near;

    assign w_out_load = ((r_state == S_EXEC) && !w_tick_run && w_out_free)
                     || ((r_state == S_FIN) && w_out_free);

    always_comb begin
        case (r_state)
            S_CK:    w_sel = MS_STIFF_DT;
            S_CC:    w_sel = MS_DAMP_DT;
            S_M0:    w_sel = MS_DX_K;
            S_M1:    w_sel = MS_DY_K;
            S_M2:    w_sel = MS_VX_C;
            S_M3:    w_sel = MS_VY_C;
            S_M5:    w_sel = MS_VX_DT;
            S_M6:    w_sel = MS_VY_DT;
            default: w_sel = MS_DX_K;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_valid ? S_EXEC : S_IDLE;
            S_EXEC: begin
                if (w_tick_run) begin
                    n_state = S_DISP;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_DISP: begin
                if (w_loop_done) begin
                    n_state = S_FIN;
                end else if (w_coef_stale) begin
                    n_state = S_CK;
                end else begin
                    n_state = S_M0;
                end
            end
            S_CK:    n_state = S_CC;
            S_CC:    n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_M6;
            S_M6:    n_state = S_M7;
            S_M7:    n_state = S_DISP;
            S_FIN:   n_state = w_out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_px      <= '0;
            r_py      <= '0;
            r_vx      <= '0;
            r_vy      <= '0;
            r_destx   <= '0;
            r_desty   <= '0;
            r_active  <= 1'b0;
            r_steps   <= '0;
            r_coef_ok <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_EXEC: begin
                    if (w_tick_run) begin
                        r_steps   <= '0;
                        r_coef_ok <= 1'b0;
                    end else if (w_out_free) begin
                        case (r_op)
                            OP_START: begin
                                r_px    <= r_fx;
                                r_py    <= r_fy;
                                r_destx <= e_clx;
                                r_desty <= e_cly;
                                if (!w_start_same) begin
                                    r_vx     <= '0;
                                    r_vy     <= '0;
                                    r_active <= 1'b1;
                                end
                            end
                            OP_RETARGET: begin
                                if (r_active) begin
                                    r_destx <= e_clx;
                                    r_desty <= e_cly;
                                end
                            end
                            OP_RECLAMP: begin
                                r_destx <= e_rcx;
                                r_desty <= e_rcy;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DISP: begin
                    if (!w_loop_done && w_coef_stale) begin
                        r_coef_ok <= 1'b1;
                    end
                end
                S_M4: r_vx <= sat32(64'(r_vx) - 64'(r_accx));
                S_M5: r_vy <= sat32(64'(r_vy) - 64'(r_accy));
                S_M6: r_px <= sat32(64'(r_px) + 64'(w_rp));
                S_M7: begin
                    r_py    <= sat32(64'(r_py) + 64'(w_rp));
                    r_steps <= r_steps + SC_W'(1);
                end
                S_FIN: begin
                    if (w_out_free && w_snap) begin
                        r_px     <= r_destx;
                        r_py     <= r_desty;
                        r_active <= 1'b0;
                    end
                end
                default: ;
            endcase

            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_op  <= i_op;
                    r_fx  <= i_from_x;
                    r_fy  <= i_from_y;
                    r_tx  <= i_to_x;
                    r_ty  <= i_to_y;
                    r_rem <= i_elapsed;
                end
            end
            S_EXEC: begin
                // sign of the displacement before the tick
                r_bgx <= r_px > r_destx;
                r_bgy <= r_py > r_desty;
            end
            S_DISP: begin
                r_dx <= 33'(r_px) - 33'(r_destx);
                r_dy <= 33'(r_py) - 33'(r_desty);
                r_dt <= w_dt;
                if (w_coef_stale) begin
                    r_coef_dt <= w_dt;
                end
            end
            S_CK: r_kdt <= w_prod[KDT_W-1:0];
            S_CC: r_cdt <= w_prod[KDT_W-1:0];
            S_M0: r_prod <= w_prod;
            S_M1: begin
                r_prod <= w_prod;
                r_accx <= w_rk;
            end
            S_M2: begin
                r_prod <= w_prod;
                r_accy <= w_rk;
            end
            S_M3: begin
                r_prod <= w_prod;
                r_accx <= r_accx + w_rc;
            end
            S_M4: r_accy <= r_accy + w_rc;
            S_M5: r_prod <= w_prod;
            S_M6: r_prod <= w_prod;
            S_M7: r_rem  <= r_rem - 16'(r_dt);
            default: ;
        endcase

        if (w_out_load) begin
            if (r_state == S_FIN) begin
                r_oacc <= 1'b1;
                r_orun <= !w_snap;
                r_ofin <= w_snap;
                r_opx  <= w_snap ? r_destx : r_px;
                r_opy  <= w_snap ? r_desty : r_py;
            end else begin
                r_oacc <= e_acc;
                r_orun <= e_run;
                r_ofin <= 1'b0;
                r_opx  <= (r_op == OP_START) ? r_fx : r_px;
                r_opy  <= (r_op == OP_START) ? r_fy : r_py;
            end
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_accepted = r_oacc;
    assign o_running  = r_orun;
    assign o_finished = r_ofin;
    assign o_pos_x    = r_opx;
    assign o_pos_y    = r_opy;

    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= SC_W'(MAX_STEPS))
        else $error("substep count beyond cap");

    a_rem_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_rem <= $past(r_rem)))
        else $error("remaining time grew during an item");

    a_dt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0) |-> ((r_dt != '0) && (r_dt <= DT_W'(STEP_TIME))))
        else $error("substep length out of range");

    a_fin_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofin) |-> !r_orun)
        else $error("finished beat still reports running");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past((r_state == S_EXEC) || (r_state == S_FIN)))
        else $error("result loaded outside a completion state");

endmodule
